// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the shuffler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and held off during reset.
`define RPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge and held off during reset.
`define RPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/rps_pkg.sv -----
// Package with the field widths, constants and control structs of the shuffler.
package rps_pkg;

	// Field widths fixed by the interface.
	localparam int WORD_W = 31;
	localparam int SIZE_W = 9;
	localparam int VAL_W  = 8;

	// Width of the remainder and divisor in the serial modulo unit.
	localparam int REM_W = 9;

	// One remainder bit is produced for each bit of the random word.
	localparam int DIV_STEPS = WORD_W;
	localparam int DIV_CNT_W = 5;

	// Run tag kept beside each table entry; tag zero marks a cleared entry.
	localparam int EPOCH_W = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST  = 8'hFF;

	// Size register value after reset.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	// Start request to the modulo unit.
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] word;
		logic [REM_W-1:0]  divisor;
	} rps_div_req_t;

	// Status returned by the modulo unit.
	typedef struct packed {
		logic             done;
		logic [REM_W-1:0] remainder;
	} rps_div_rsp_t;

endpackage

// ----- hw/rtl/random_permutation_shuffler.sv -----
// Top level of the forward Fisher-Yates permutation shuffler.
//
//  Channel     Handshake                  Payload
//  ----------  -------------------------  ---------------------------------------
//  size write  perm_size_we               perm_size
//  request in  rnd_valid / rnd_stall      random_word
//  result out  perm_valid / perm_stall    position, chosen_index, last_flag
//
// Each request runs from acceptance to the next acceptance through the table RAM port reading
// i, the bit-serial remainder of the random word by n - i, and the RAM port reading j and
// writing i and j back one after the other.
// After reset a clearing pass tags every table entry as unwritten; the same pass runs again
// after every 255 completed permutations, when the run tag wraps.
// A stalled result holds in the output register; the next request still runs, then waits.
module random_permutation_shuffler #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       perm_size_we,
	input  logic [rps_pkg::SIZE_W-1:0] perm_size,
	input  logic                       rnd_valid,
	output logic                       rnd_stall,
	input  logic [rps_pkg::WORD_W-1:0] random_word,
	output logic                       perm_valid,
	input  logic                       perm_stall,
	output logic [rps_pkg::VAL_W-1:0]  position,
	output logic [rps_pkg::VAL_W-1:0]  chosen_index,
	output logic                       last_flag
);

	localparam int AW    = $clog2(MAX_ENTRIES);
	localparam int CW    = ((AW > rps_pkg::SIZE_W) ? AW : rps_pkg::SIZE_W) + 1;
	localparam int RAM_W = rps_pkg::EPOCH_W + rps_pkg::VAL_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ENTRIES - 1);

	// Sequencer states.
	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RDI  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_RDJ  = 3'd4;
	localparam logic [2:0] ST_WRI  = 3'd5;
	localparam logic [2:0] ST_WRJ  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0]                  state_q;
	logic [rps_pkg::SIZE_W-1:0]  perm_size_q;
	logic [AW-1:0]               step_q;
	logic [AW-1:0]               clr_q;
	logic [rps_pkg::EPOCH_W-1:0] epoch_q;
	logic                        perm_valid_q;

	logic [AW-1:0]              j_q;
	logic                       last_q;
	logic [rps_pkg::VAL_W-1:0]  vi_q;
	logic [rps_pkg::VAL_W-1:0]  vj_q;
	logic [rps_pkg::VAL_W-1:0]  position_q;
	logic [rps_pkg::VAL_W-1:0]  chosen_q;
	logic                       last_out_q;

	logic [rps_pkg::SIZE_W-1:0]  n_eff;
	logic                        step_last;
	logic [CW-1:0]               divisor_full;
	logic                        accept;
	logic                        out_free;
	logic [AW-1:0]               j_next;
	logic [rps_pkg::EPOCH_W-1:0] rd_epoch;
	logic [rps_pkg::VAL_W-1:0]   rd_val;
	logic                        rd_hit;
	logic [rps_pkg::VAL_W-1:0]   vi_rd;
	logic [rps_pkg::VAL_W-1:0]   vj_rd;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [RAM_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [RAM_W-1:0] ram_rdata;

	rps_pkg::rps_div_req_t div_req;
	rps_pkg::rps_div_rsp_t div_rsp;

	// Effective size, clamped to one up to the table depth.
	always_comb begin
		if (perm_size_q == '0) begin
			n_eff = rps_pkg::SIZE_W'(1);
		end else if (int'(perm_size_q) > MAX_ENTRIES) begin
			n_eff = rps_pkg::SIZE_W'(MAX_ENTRIES);
		end else begin
			n_eff = perm_size_q;
		end
	end

	// Last-step test and divisor for the current position.
	assign step_last    = (CW'(step_q) + CW'(1)) >= CW'(n_eff);
	assign divisor_full = CW'(n_eff) - CW'(step_q);

	assign accept    = rnd_valid && (state_q == ST_IDLE);
	assign rnd_stall = (state_q != ST_IDLE);
	assign out_free  = !perm_valid_q || !perm_stall;

	// Start the remainder as soon as a request is accepted.
	assign div_req.start   = accept;
	assign div_req.word    = random_word;
	assign div_req.divisor = divisor_full[rps_pkg::REM_W-1:0];

	rps_mod_serial u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Swap partner: the position itself on the last step.
	assign j_next = last_q ? step_q : AW'(CW'(step_q) + CW'(div_rsp.remainder));

	// An entry whose tag is not the current run reads as its own address.
	assign rd_epoch = ram_rdata[RAM_W-1 -: rps_pkg::EPOCH_W];
	assign rd_val   = ram_rdata[rps_pkg::VAL_W-1:0];
	assign rd_hit   = (rd_epoch == epoch_q);
	assign vi_rd    = rd_hit ? rd_val : rps_pkg::VAL_W'(step_q);
	assign vj_rd    = rd_hit ? rd_val : rps_pkg::VAL_W'(j_q);

	// Read address: the partner while it is fetched, the position otherwise.
	assign ram_raddr = (state_q == ST_RDJ) ? j_q : step_q;

	// Write port selection for the clearing pass and the two halves of the swap.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = step_q;
		ram_wdata = {epoch_q, vj_rd};
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_WRI: begin
				ram_we    = 1'b1;
				ram_waddr = step_q;
				ram_wdata = {epoch_q, vj_rd};
			end
			ST_WRJ: begin
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = {epoch_q, vi_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	rps_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, size register, step counter, run tag and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLR;
			perm_size_q  <= rps_pkg::SIZE_RESET;
			step_q       <= '0;
			clr_q        <= '0;
			epoch_q      <= rps_pkg::EPOCH_FIRST;
			perm_valid_q <= 1'b0;
		end else begin
			if (perm_size_we) begin
				perm_size_q <= perm_size;
			end
			// The result state loads its own valid, so the release is taken elsewhere.
			if (perm_valid_q && !perm_stall && (state_q != ST_OUT)) begin
				perm_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					if (clr_q == LAST_ADDR) begin
						clr_q   <= '0;
						epoch_q <= rps_pkg::EPOCH_FIRST;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (rnd_valid) begin
						state_q <= ST_RDI;
					end
				end
				ST_RDI: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_RDJ;
					end
				end
				ST_RDJ: begin
					state_q <= ST_WRI;
				end
				ST_WRI: begin
					state_q <= ST_WRJ;
				end
				ST_WRJ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						perm_valid_q <= 1'b1;
						if (last_q) begin
							step_q <= '0;
							if (epoch_q == rps_pkg::EPOCH_LAST) begin
								state_q <= ST_CLR;
							end else begin
								epoch_q <= epoch_q + rps_pkg::EPOCH_W'(1);
								state_q <= ST_IDLE;
							end
						end else begin
							step_q  <= step_q + AW'(1);
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

	// Captured operands and the result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= step_last;
		end
		if (state_q == ST_RDI) begin
			vi_q <= vi_rd;
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			j_q <= j_next;
		end
		if (state_q == ST_WRI) begin
			vj_q <= vj_rd;
		end
		if ((state_q == ST_OUT) && out_free) begin
			position_q <= rps_pkg::VAL_W'(step_q);
			chosen_q   <= vj_q;
			last_out_q <= last_q;
		end
	end

	assign perm_valid   = perm_valid_q;
	assign position     = position_q;
	assign chosen_index = chosen_q;
	assign last_flag    = last_out_q;

endmodule

// ----- hw/rtl/rps_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module rps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/rps_mod_serial.sv -----
// Bit-serial restoring modulo unit: one remainder bit per clock cycle.
module rps_mod_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  rps_pkg::rps_div_req_t req,
	output rps_pkg::rps_div_rsp_t rsp
);

	logic [rps_pkg::WORD_W-1:0]    word_q;
	logic [rps_pkg::REM_W-1:0]     div_q;
	logic [rps_pkg::REM_W-1:0]     rem_q;
	logic [rps_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [rps_pkg::REM_W:0]   trial;
	logic                      fits;
	logic [rps_pkg::REM_W-1:0] next_rem;

	// Shift the next word bit into the partial remainder and subtract the divisor if it fits.
	always_comb begin
		trial    = {rem_q, word_q[rps_pkg::WORD_W-1]};
		fits     = trial >= {1'b0, div_q};
		next_rem = fits ? rps_pkg::REM_W'(trial - {1'b0, div_q})
		                : trial[rps_pkg::REM_W-1:0];
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= rps_pkg::DIV_CNT_W'(rps_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - rps_pkg::DIV_CNT_W'(1);
			if (cnt_q == rps_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Word shift register and partial remainder.
	always_ff @(posedge clk) begin
		if (req.start) begin
			word_q <= req.word;
			div_q  <= req.divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			word_q <= {word_q[rps_pkg::WORD_W-2:0], 1'b0};
			rem_q  <= next_rem;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- hw/rtl/rps_checker.sv -----
// Port-level checker for the shuffler and the bind that attaches it.
`include "assert_macros.svh"

module rps_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rnd_valid,
	input logic                       rnd_stall,
	input logic [rps_pkg::WORD_W-1:0] random_word,
	input logic                       perm_valid,
	input logic                       perm_stall,
	input logic [rps_pkg::VAL_W-1:0]  position,
	input logic [rps_pkg::VAL_W-1:0]  chosen_index,
	input logic                       last_flag
);

	// One request at a time: the cycle after an acceptance the input is stalled.
	`RPS_ASSERT_NEXT(a_one_request, rnd_valid && !rnd_stall, rnd_stall, "request accepted while busy")

	// A stalled request stays offered and unchanged.
	`RPS_ASSERT_NEXT(a_request_holds, rnd_valid && rnd_stall, rnd_valid && $stable(random_word), "stalled request changed")

	// A result only appears after the input has been held off for the step.
	`RPS_ASSERT_SAME(a_result_after_work, $rose(perm_valid), $past(rnd_stall), "result without a completed step")

	// A stalled result stays offered and unchanged.
	`RPS_ASSERT_NEXT(a_result_holds, perm_valid && perm_stall, perm_valid && $stable(position) && $stable(chosen_index) && $stable(last_flag), "stalled result changed")

endmodule

bind random_permutation_shuffler rps_checker u_rps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rnd_valid    (rnd_valid),
	.rnd_stall    (rnd_stall),
	.random_word  (random_word),
	.perm_valid   (perm_valid),
	.perm_stall   (perm_stall),
	.position     (position),
	.chosen_index (chosen_index),
	.last_flag    (last_flag)
);
